// File: hdl/eeb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eeb_pkg
// shared types and constants for the extended euclid bezout block
// ----------------------------------------------------------------------------
package eeb_pkg;

	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);

	typedef struct packed {
		logic b_zero;
		logic a_zero;
	} eeb_cls_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_UPD,
		ST_FIN
	} eeb_state_t;

endpackage
`default_nettype wire

// File: hdl/eeb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eeb_front
// accepts operand beats, flags zero operands and offers a job to the queue
// ----------------------------------------------------------------------------
module eeb_front #(
	parameter int DATA_WIDTH = 32
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    opnd_valid,
	output logic                   opnd_stall,
	input  wire [DATA_WIDTH-2:0]   operand_a,
	input  wire [DATA_WIDTH-2:0]   operand_b,
	output logic                   push_valid,
	input  wire                    push_stall,
	output logic [DATA_WIDTH-2:0]  push_a,
	output logic [DATA_WIDTH-2:0]  push_b,
	output eeb_pkg::eeb_cls_t      push_cls
);
	import eeb_pkg::*;

	localparam int OW = DATA_WIDTH - 1;

	logic          v_s1;
	logic [OW-1:0] a_s1;
	logic [OW-1:0] b_s1;
	eeb_cls_t      cls_s1;

	assign opnd_stall = v_s1 && push_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!opnd_stall) begin
			v_s1 <= opnd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!opnd_stall && opnd_valid) begin
			a_s1          <= operand_a;
			b_s1          <= operand_b;
			cls_s1.a_zero <= (operand_a == '0);
			cls_s1.b_zero <= (operand_b == '0);
		end
	end

	assign push_valid = v_s1;
	assign push_a     = a_s1;
	assign push_b     = b_s1;
	assign push_cls   = cls_s1;

endmodule
`default_nettype wire

// File: hdl/eeb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eeb_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module eeb_queue #(
	parameter int WIDTH = 64
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	output logic             push_stall,
	input  wire [WIDTH-1:0]  push_data,
	output logic             pop_valid,
	input  wire              pop_stall,
	output logic [WIDTH-1:0] pop_data
);
	import eeb_pkg::*;

	logic [WIDTH-1:0] mem_q [QDEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QPW:0]     cnt_q;
	logic             push;
	logic             pop;

	assign push_stall = (cnt_q == (QPW+1)'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/eeb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eeb_back
// euclid engine: bit-serial division with shift-add coefficient products
// ----------------------------------------------------------------------------
module eeb_back #(
	parameter int DATA_WIDTH = 32
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    pop_valid,
	output logic                   pop_stall,
	input  wire [DATA_WIDTH-2:0]   job_a,
	input  wire [DATA_WIDTH-2:0]   job_b,
	input  eeb_pkg::eeb_cls_t      job_cls,
	output logic                   res_valid,
	input  wire                    res_stall,
	output logic [DATA_WIDTH-2:0]  gcd_value,
	output logic [DATA_WIDTH-1:0]  coeff_x,
	output logic [DATA_WIDTH-1:0]  coeff_y
);
	import eeb_pkg::*;

	localparam int OW = DATA_WIDTH - 1;
	localparam int DW = DATA_WIDTH;
	localparam int CW = $clog2(OW);

	eeb_state_t    state_q;
	eeb_state_t    state_d;
	logic          pop;
	logic          fin_load;
	logic          last_bit;

	logic [OW-1:0] r0_q;
	logic [OW-1:0] r1_q;
	logic [OW-1:0] rem_q;
	logic [OW-1:0] dvd_q;
	logic [DW-1:0] x0_q;
	logic [DW-1:0] x1_q;
	logic [DW-1:0] y0_q;
	logic [DW-1:0] y1_q;
	logic [DW-1:0] accx_q;
	logic [DW-1:0] accy_q;
	logic [CW-1:0] cnt_q;
	logic          res_valid_q;

	logic [OW:0]   trial;
	logic          ge;
	logic [OW:0]   diff;

	assign trial    = {rem_q, dvd_q[OW-1]};
	assign ge       = (trial >= {1'b0, r1_q});
	assign diff     = trial - {1'b0, r1_q};
	assign last_bit = (cnt_q == CW'(OW - 1));
	assign pop      = pop_valid && !pop_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					state_d = (job_cls.a_zero || job_cls.b_zero) ? ST_FIN : ST_DIV;
				end
			end
			ST_DIV: begin
				if (last_bit) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				state_d = (rem_q == '0) ? ST_FIN : ST_DIV;
			end
			ST_FIN: begin
				if (fin_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop_stall = 1'b1;
		fin_load  = 1'b0;
		case (state_q)
			ST_IDLE: pop_stall = 1'b0;
			ST_FIN:  fin_load  = !res_valid_q || !res_stall;
			default: begin
				pop_stall = 1'b1;
				fin_load  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					if (job_cls.b_zero) begin
						r0_q <= job_a;
						x0_q <= DW'(1);
						y0_q <= '0;
					end else if (job_cls.a_zero) begin
						r0_q <= job_b;
						x0_q <= '0;
						y0_q <= DW'(1);
					end else begin
						r0_q <= job_a;
						x0_q <= DW'(1);
						y0_q <= '0;
					end
					r1_q   <= job_b;
					x1_q   <= '0;
					y1_q   <= DW'(1);
					dvd_q  <= job_a;
					rem_q  <= '0;
					accx_q <= '0;
					accy_q <= '0;
					cnt_q  <= '0;
				end
			end
			ST_DIV: begin
				rem_q  <= ge ? diff[OW-1:0] : trial[OW-1:0];
				dvd_q  <= {dvd_q[OW-2:0], 1'b0};
				accx_q <= {accx_q[DW-2:0], 1'b0} + (ge ? x1_q : '0);
				accy_q <= {accy_q[DW-2:0], 1'b0} + (ge ? y1_q : '0);
				cnt_q  <= cnt_q + 1'b1;
			end
			ST_UPD: begin
				r0_q   <= r1_q;
				r1_q   <= rem_q;
				x0_q   <= x1_q;
				x1_q   <= x0_q - accx_q;
				y0_q   <= y1_q;
				y1_q   <= y0_q - accy_q;
				dvd_q  <= r1_q;
				rem_q  <= '0;
				accx_q <= '0;
				accy_q <= '0;
				cnt_q  <= '0;
			end
			ST_FIN: begin
				if (fin_load) begin
					gcd_value <= r0_q;
					coeff_x   <= x0_q;
					coeff_y   <= y0_q;
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	assign res_valid = res_valid_q;

endmodule
`default_nettype wire

// File: hdl/extended_euclid_bezout.sv
`default_nettype none
// ----------------------------------------------------------------------------
// extended_euclid_bezout
// gcd and bezout coefficients of two non-negative operands
// ----------------------------------------------------------------------------
// One result beat per operand beat: gcd_value and signed coeff_x, coeff_y with
// operand_a*coeff_x + operand_b*coeff_y = gcd_value. A zero operand_b gives
// (operand_a, 1, 0); a zero operand_a with nonzero operand_b gives
// (operand_b, 0, 1). In each Euclid iteration the quotient comes out of a
// restoring divider one bit per cycle while the two coefficient products
// accumulate by shift and add, then an update state moves the remainders and
// coefficients on. An item takes at most about 46 iterations for the default
// width. A front stage and a two-entry queue keep taking operand beats while
// the engine works, and a finished result waits in an output register; the
// engine works on the next job but waits in its final state while that register is full.
// ----------------------------------------------------------------------------
module extended_euclid_bezout #(
	parameter int DATA_WIDTH = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          opnd_valid,
	output logic                         opnd_stall,
	input  wire [DATA_WIDTH-2:0]         operand_a,
	input  wire [DATA_WIDTH-2:0]         operand_b,
	output logic                         res_valid,
	input  wire                          res_stall,
	output logic [DATA_WIDTH-2:0]        gcd_value,
	output logic signed [DATA_WIDTH-1:0] coeff_x,
	output logic signed [DATA_WIDTH-1:0] coeff_y
);
	import eeb_pkg::*;

	localparam int OW = DATA_WIDTH - 1;
	localparam int EW = 2 * OW + $bits(eeb_cls_t);

	logic          push_valid;
	logic          push_stall;
	logic [OW-1:0] push_a;
	logic [OW-1:0] push_b;
	eeb_cls_t      push_cls;
	logic          pop_valid;
	logic          pop_stall;
	logic [EW-1:0] pop_data;
	eeb_cls_t      job_cls;
	logic [OW-1:0] job_a;
	logic [OW-1:0] job_b;
	logic [DATA_WIDTH-1:0] cx;
	logic [DATA_WIDTH-1:0] cy;

	eeb_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.opnd_valid (opnd_valid),
		.opnd_stall (opnd_stall),
		.operand_a  (operand_a),
		.operand_b  (operand_b),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_a     (push_a),
		.push_b     (push_b),
		.push_cls   (push_cls)
	);

	eeb_queue #(.WIDTH(EW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_data  ({push_cls, push_a, push_b}),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_data   (pop_data)
	);

	assign {job_cls, job_a, job_b} = pop_data;

	eeb_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.job_a      (job_a),
		.job_b      (job_b),
		.job_cls    (job_cls),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.gcd_value  (gcd_value),
		.coeff_x    (cx),
		.coeff_y    (cy)
	);

	assign coeff_x = cx;
	assign coeff_y = cy;

	// accepted operand beat sits in the front stage next cycle
	a_front_load: assert property (@(posedge clk) disable iff (!arst_n)
		opnd_valid && !opnd_stall |=> push_valid)
		else $error("front stage lost an accepted beat");

	// engine takes one job at a time
	a_single_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid && !pop_stall |=> pop_stall)
		else $error("engine popped while busy");

	// full queue is never empty
	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push_stall |-> pop_valid)
		else $error("queue full flag without data");

	// a new result only follows engine work
	a_res_from_engine: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(pop_stall))
		else $error("result appeared without a job");

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// testbench for the extended euclid bezout block
// ----------------------------------------------------------------------------
// Operand pairs go in from a queue: first a few hand-picked edge cases, then
// random pairs. The mix covers full-range values, shared factors, small values,
// zeros and near-maximum values. A local solver works out gcd and coefficients
// for every accepted operand beat. Each result beat is checked field by field
// against the oldest pending answer. Both sides idle at random. The receiver
// holds off once for a long stretch so that the block fills up and stalls its
// input. The sender once waits until every pending answer has come back.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int DW          = 32;
	localparam int N_RANDOM    = 380;
	localparam int HOLD_AT     = 40;
	localparam int HOLD_CYCLES = 8000;
	localparam int DRAIN_AT    = 300;
	localparam int TAIL_CYCLES = 2000;
	localparam int IDLE_LIMIT  = 30000;

	localparam logic [DW-2:0] OPND_MAX = '1;
	localparam logic [DW-2:0] FIB_45   = 31'd1134903170;
	localparam logic [DW-2:0] FIB_46   = 31'd1836311903;

	typedef struct packed {
		logic [DW-2:0] a;
		logic [DW-2:0] b;
	} operand_pair_t;

	typedef struct packed {
		logic [DW-2:0]        gcd;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
	} bezout_t;

	logic                 clk;
	logic                 arst_n;
	logic                 opnd_valid;
	logic                 opnd_stall;
	logic [DW-2:0]        operand_a;
	logic [DW-2:0]        operand_b;
	logic                 res_valid;
	logic                 res_stall;
	logic [DW-2:0]        gcd_value;
	logic signed [DW-1:0] coeff_x;
	logic signed [DW-1:0] coeff_y;

	operand_pair_t operand_q[$];
	bezout_t       bezout_q[$];

	int fail_cnt;
	int pairs_sent;
	int gap_left;
	int burst_left;
	int results_seen;
	int hold_left;
	bit hold_done;
	bit rx_stalling;
	int rx_run;
	int idle_cycles;

	extended_euclid_bezout #(
		.DATA_WIDTH(DW)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.opnd_valid(opnd_valid),
		.opnd_stall(opnd_stall),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.gcd_value (gcd_value),
		.coeff_x   (coeff_x),
		.coeff_y   (coeff_y)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// extended euclid with coefficients kept modulo 2^64
	function automatic bezout_t bezout_solve(input logic [DW-2:0] a, input logic [DW-2:0] b);
		logic [63:0] r0, r1, x0, x1, y0, y1, q, t;
		bezout_t res;
		r0 = 64'(a);
		r1 = 64'(b);
		x0 = 64'd1;
		x1 = 64'd0;
		y0 = 64'd0;
		y1 = 64'd1;
		while (r1 != 64'd0) begin
			q  = r0 / r1;
			t  = x0 - q * x1;
			x0 = x1;
			x1 = t;
			t  = y0 - q * y1;
			y0 = y1;
			y1 = t;
			t  = r0 - q * r1;
			r0 = r1;
			r1 = t;
		end
		res.gcd = r0[DW-2:0];
		res.x   = x0[DW-1:0];
		res.y   = y0[DW-1:0];
		return res;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 20);
		else
			return $urandom_range(30, 200);
	endfunction

	function automatic operand_pair_t random_pair();
		operand_pair_t p;
		int kind;
		logic [DW-2:0] g;
		kind = $urandom_range(0, 99);
		p.a = 31'($urandom());
		p.b = 31'($urandom());
		if (kind < 55) begin
		end else if (kind < 70) begin
			g   = 31'($urandom_range(1, 65535));
			p.a = g * 31'($urandom_range(0, 32767));
			p.b = g * 31'($urandom_range(0, 32767));
		end else if (kind < 80) begin
			p.a = 31'($urandom_range(0, 255));
			p.b = 31'($urandom_range(0, 255));
		end else if (kind < 88) begin
			p.b = p.a >> $urandom_range(0, 30);
			if ($urandom_range(0, 1) == 1)
				p = '{a: p.b, b: p.a};
		end else if (kind < 94) begin
			case ($urandom_range(0, 2))
				0: p.a = '0;
				1: p.b = '0;
				default: begin
					p.a = '0;
					p.b = '0;
				end
			endcase
		end else begin
			p.a = OPND_MAX - 31'($urandom_range(0, 1000));
			p.b = OPND_MAX - 31'($urandom_range(0, 1000));
		end
		return p;
	endfunction

	// stimulus, reset and end of run
	initial begin
		arst_n = 1'b0;
		operand_q.push_back('{a: 31'd0, b: 31'd0});
		operand_q.push_back('{a: 31'd7, b: 31'd0});
		operand_q.push_back('{a: 31'd0, b: 31'd9});
		operand_q.push_back('{a: OPND_MAX, b: 31'd0});
		operand_q.push_back('{a: 31'd0, b: OPND_MAX});
		operand_q.push_back('{a: OPND_MAX, b: OPND_MAX});
		operand_q.push_back('{a: OPND_MAX, b: 31'd1});
		operand_q.push_back('{a: 31'd1, b: OPND_MAX});
		operand_q.push_back('{a: 31'd1, b: 31'd1});
		operand_q.push_back('{a: FIB_46, b: FIB_45});
		operand_q.push_back('{a: FIB_45, b: FIB_46});
		operand_q.push_back('{a: OPND_MAX, b: OPND_MAX - 31'd1});
		operand_q.push_back('{a: 31'h4000_0000, b: 31'h2000_0000});
		operand_q.push_back('{a: 31'h4000_0000, b: 31'd3});
		operand_q.push_back('{a: 31'd240, b: 31'd46});
		operand_q.push_back('{a: 31'd46, b: 31'd240});
		operand_q.push_back('{a: 31'd12, b: 31'd18});
		operand_q.push_back('{a: 31'd1000000007, b: 31'd998244353});
		operand_q.push_back('{a: 31'h5555_5555, b: 31'h2aaa_aaaa});
		operand_q.push_back('{a: 31'h2aaa_aaaa, b: 31'h5555_5555});
		for (int i = 0; i < N_RANDOM; i++)
			operand_q.push_back(random_pair());

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (operand_q.size() != 0 || opnd_valid || bezout_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_cnt == 0 && bezout_q.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	// operand driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opnd_valid <= 1'b0;
			operand_a  <= '0;
			operand_b  <= '0;
			gap_left   = 0;
			burst_left = 0;
			pairs_sent = 0;
		end else begin
			if (opnd_valid && !opnd_stall)
				bezout_q.push_back(bezout_solve(operand_a, operand_b));
			if (!(opnd_valid && opnd_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					opnd_valid <= 1'b0;
				end else if (pairs_sent == DRAIN_AT && bezout_q.size() != 0) begin
					opnd_valid <= 1'b0;
				end else if (operand_q.size() != 0) begin
					operand_a  <= operand_q[0].a;
					operand_b  <= operand_q[0].b;
					opnd_valid <= 1'b1;
					void'(operand_q.pop_front());
					pairs_sent++;
					if (burst_left > 0)
						burst_left--;
					else if ($urandom_range(0, 15) == 0)
						burst_left = $urandom_range(5, 30);
					gap_left = (burst_left > 0) ? 0 : idle_len();
				end else begin
					opnd_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall    <= 1'b0;
			results_seen = 0;
			hold_left    = 0;
			hold_done    = 1'b0;
			rx_stalling  = 1'b1;
			rx_run       = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (bezout_q.size() == 0) begin
					fail_cnt++;
					$display("%0t: unexpected result beat gcd=%0d x=%0d y=%0d",
						$time, gcd_value, coeff_x, coeff_y);
				end else begin
					if (bezout_q[0].gcd !== gcd_value) begin
						fail_cnt++;
						$display("%0t: gcd_value expected %0d got %0d",
							$time, bezout_q[0].gcd, gcd_value);
					end
					if (bezout_q[0].x !== coeff_x) begin
						fail_cnt++;
						$display("%0t: coeff_x expected %0d got %0d",
							$time, bezout_q[0].x, coeff_x);
					end
					if (bezout_q[0].y !== coeff_y) begin
						fail_cnt++;
						$display("%0t: coeff_y expected %0d got %0d",
							$time, bezout_q[0].y, coeff_y);
					end
					void'(bezout_q.pop_front());
				end
				results_seen++;
				if (!hold_done && results_seen == HOLD_AT) begin
					hold_left = HOLD_CYCLES;
					hold_done = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				if (rx_run == 0) begin
					rx_stalling = !rx_stalling;
					if (rx_stalling)
						rx_run = idle_len();
					else if ($urandom_range(0, 9) == 0)
						rx_run = $urandom_range(50, 300);
					else
						rx_run = $urandom_range(1, 20);
				end
				res_stall <= rx_stalling && rx_run > 0;
				if (rx_run > 0)
					rx_run--;
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if ((opnd_valid && !opnd_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, idle_cycles);
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

endmodule

// File: extended_euclid_bezout.f
hdl/eeb_pkg.sv
hdl/eeb_front.sv
hdl/eeb_queue.sv
hdl/eeb_back.sv
hdl/extended_euclid_bezout.sv
test/tb_top.sv
